### design/bsfd_pkg.sv
package bsfd_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_DISTANCE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_BALL_CODE   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LIMIT    = 2'd2;

  localparam logic [7:0] DISTANCE_LIMIT_RST = 8'd100;
  localparam logic [7:0] NO_BALL_CODE_RST   = 8'd200;
  localparam logic [3:0] ERROR_LIMIT_RST    = 4'd5;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [9:0] ANGLE_OFFSET = 10'd315;
  localparam logic [9:0] FULL_TURN    = 10'd360;
  localparam logic [9:0] TWO_TURNS    = 10'd720;
  localparam logic [9:0] HALF_TURN    = 10'd180;
  localparam logic signed [8:0] EDGE_ANGLE = 9'sd179;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CODE   = 2'd1,
    PH_DIST   = 2'd2
  } bsfd_phase_t;

  typedef struct packed {
    logic [7:0] distance_limit;
    logic [7:0] no_ball_code;
    logic [3:0] error_limit;
  } bsfd_cfg_t;

  typedef struct packed {
    bsfd_phase_t        phase;
    logic [7:0]         angle_code;
    logic [7:0]         distance;
    logic signed [8:0]  angle;
    logic               visible;
    logic [3:0]         error_count;
  } bsfd_state_t;

  typedef struct packed {
    logic signed [8:0] ball_angle;
    logic [7:0]        ball_distance;
    logic              ball_visible;
    logic              frame_done;
    logic              link_warning;
  } bsfd_result_t;

endpackage

### design/bsfd_step.sv
module bsfd_step import bsfd_pkg::*; (
  input  bsfd_state_t  state,
  input  bsfd_cfg_t    cfg,
  input  logic [7:0]   rx_byte,
  output bsfd_state_t  state_next,
  output bsfd_result_t result
);

  logic [9:0]        angle_sum;
  logic [9:0]        angle_mod;
  logic signed [8:0] angle_calc;
  logic [7:0]        dist_new;
  logic              no_ball;
  logic              done;
  logic              count_up;
  logic              clear_count;
  logic [4:0]        count_wide;
  logic              warn;

  // 2*code + 315 stays below 1080, so two conditional subtractions cover the modulo.
  always_comb begin
    angle_sum = {1'b0, state.angle_code, 1'b0} + ANGLE_OFFSET;
    if (angle_sum >= TWO_TURNS) begin
      angle_mod = angle_sum - TWO_TURNS;
    end else if (angle_sum >= FULL_TURN) begin
      angle_mod = angle_sum - FULL_TURN;
    end else begin
      angle_mod = angle_sum;
    end
    angle_calc = 9'(signed'(angle_mod - HALF_TURN));
  end

  always_comb begin
    state_next  = state;
    done        = 1'b0;
    count_up    = 1'b0;
    clear_count = 1'b0;
    dist_new    = (rx_byte < cfg.distance_limit) ? rx_byte : state.distance;
    no_ball     = (state.angle_code == cfg.no_ball_code) || (dist_new == 8'd0);

    unique case (state.phase)
      PH_CODE: begin
        state_next.angle_code = rx_byte;
        state_next.phase      = PH_DIST;
      end
      PH_DIST: begin
        state_next.distance = dist_new;
        if (no_ball) begin
          state_next.visible = 1'b0;
          state_next.angle   = 9'sd0;
        end else begin
          state_next.angle   = angle_calc;
          state_next.visible = (angle_calc != EDGE_ANGLE) && (angle_calc != -EDGE_ANGLE);
        end
        state_next.phase = PH_HEADER;
        clear_count      = 1'b1;
        done             = 1'b1;
      end
      default: begin
        if (rx_byte == HEADER_BYTE) begin
          state_next.phase = PH_CODE;
        end else begin
          state_next.phase = PH_HEADER;
          count_up         = 1'b1;
        end
      end
    endcase

    // The count is compared one bit wider so that a limit of 15 trips on the sixteenth error.
    count_wide = clear_count ? 5'd0 : ({1'b0, state.error_count} + {4'd0, count_up});
    warn       = count_wide > {1'b0, cfg.error_limit};
    state_next.error_count = warn ? 4'd0 : count_wide[3:0];

    result.ball_angle    = state_next.angle;
    result.ball_distance = state_next.distance;
    result.ball_visible  = state_next.visible;
    result.frame_done    = done;
    result.link_warning  = warn;
  end

endmodule

### design/bsfd_skid.sv
module bsfd_skid import bsfd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  bsfd_result_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output bsfd_result_t out_data
);

  logic         skid_valid;
  bsfd_result_t skid_data;
  logic         take;
  logic         accept;
  logic         load_out;

  assign in_stall = skid_valid;
  assign take     = out_valid && !out_stall;
  assign accept   = in_valid && !skid_valid;
  assign load_out = take || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // A beat that arrives while the output register is held parks in the skid register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (accept) begin
      skid_data <= in_data;
    end
  end

endmodule

### design/ball_sensor_frame_decoder.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  rx_byte
// result    out        out_valid/out_stall  ball_angle, ball_distance, ball_visible,
//                                           frame_done, link_warning
// config    in         cfg_write            cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each result is registered for output.
// The frame state updates in the accepting cycle, so consecutive bytes need no gap.
// Reset (rst, synchronous) clears the frame state and loads the register defaults.
// A two-entry output stage keeps the input open during a single stalled result;
// in_stall rises only while both entries hold undelivered beats.
module ball_sensor_frame_decoder import bsfd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [8:0]      ball_angle,
  output logic [7:0]             ball_distance,
  output logic                   ball_visible,
  output logic                   frame_done,
  output logic                   link_warning,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  bsfd_cfg_t    cfg;
  bsfd_state_t  state;
  bsfd_state_t  state_next;
  bsfd_result_t step_result;
  bsfd_result_t out_data;
  logic         in_accept;

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.distance_limit <= DISTANCE_LIMIT_RST;
      cfg.no_ball_code   <= NO_BALL_CODE_RST;
      cfg.error_limit    <= ERROR_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DISTANCE_LIMIT: cfg.distance_limit <= cfg_data;
        CFG_NO_BALL_CODE:   cfg.no_ball_code   <= cfg_data;
        CFG_ERROR_LIMIT:    cfg.error_limit    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_HEADER;
      state.angle_code  <= 8'd0;
      state.distance    <= 8'd0;
      state.angle       <= 9'sd0;
      state.visible     <= 1'b0;
      state.error_count <= 4'd0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  bsfd_step u_step (
    .state      (state),
    .cfg        (cfg),
    .rx_byte    (rx_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  bsfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (step_result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign ball_angle    = out_data.ball_angle;
  assign ball_distance = out_data.ball_distance;
  assign ball_visible  = out_data.ball_visible;
  assign frame_done    = out_data.frame_done;
  assign link_warning  = out_data.link_warning;

  // The input closes only behind a held result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // Completing a frame clears the error count, so it can never warn.
  a_frame_no_warning: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_done) |-> !link_warning)
    else $error("link warning on a completed frame");

  // A visible ball has a nonzero distance and is not at the sensor's blind edge.
  a_visible_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ball_visible) |->
      (ball_distance != 8'd0 && ball_angle != EDGE_ANGLE && ball_angle != -EDGE_ANGLE))
    else $error("ball visible with zero distance or edge angle");

endmodule
